>>> src/hilbert_curve_index_converter_core_assert.svh
// assertion macros shared by the converter modules
// expects clk and arst_n in the scope of each use
`ifndef HILBERT_CURVE_INDEX_CONVERTER_CORE_ASSERT_SVH
`define HILBERT_CURVE_INDEX_CONVERTER_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define HCIC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define HCIC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/hcic_pkg.sv
// shared types and constants of the hilbert curve index converter
// no dependencies
package hcic_pkg;

	// conversion direction carried in tuser
	typedef enum logic {
		KIND_XY2D = 1'b0,
		KIND_D2XY = 1'b1
	} kind_t;

	localparam int COORD_W     = 16;
	localparam int INDEX_W     = 32;
	localparam int CFG_W       = 5;
	localparam int ORDER_RESET = 8;
	localparam int S_TDATA_W   = 2 * COORD_W + INDEX_W;
	localparam int M_TDATA_W   = INDEX_W + 2 * COORD_W;

endpackage

>>> src/hilbert_curve_index_converter_core.sv
// Hilbert curve converter between grid points and curve distances. Each transaction
// on s_axis carries a direction in s_tuser and produces exactly one result transaction
// on m_axis. A new transaction is taken every clock cycle unless m_axis stalls; each
// cell in the chain registers the item and handles one bit level of the grid.
// curve_order must be written through cfg_valid/cfg_data only while no transaction is
// in flight; the block itself does not enforce this. Values above MAX_ORDER act as MAX_ORDER.
// depends on hcic_pkg, hcic_cell and the assertion header
`include "hilbert_curve_index_converter_core_assert.svh"

module hilbert_curve_index_converter_core #(
	parameter int MAX_ORDER = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [hcic_pkg::CFG_W-1:0]        cfg_data,   // curve_order
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [hcic_pkg::S_TDATA_W-1:0]    s_tdata,    // coord_x, coord_y, curve_index
	input  logic [0:0]                        s_tuser,    // kind
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [hcic_pkg::M_TDATA_W-1:0]    m_tdata     // out_index, out_x, out_y
);

	localparam int OW    = $clog2(MAX_ORDER + 1);
	localparam int CW    = MAX_ORDER;
	localparam int IW    = 2 * MAX_ORDER;
	localparam int CRD_W = hcic_pkg::COORD_W;
	localparam int IDX_W = hcic_pkg::INDEX_W;
	localparam int RST_O = (hcic_pkg::ORDER_RESET > MAX_ORDER) ? MAX_ORDER
		: hcic_pkg::ORDER_RESET;
	localparam logic [hcic_pkg::CFG_W-1:0] MAX_CFG = hcic_pkg::CFG_W'(MAX_ORDER);

	logic [OW-1:0] order_q;

	logic              c_valid [0:MAX_ORDER];
	logic              c_ready [0:MAX_ORDER];
	hcic_pkg::kind_t   c_kind  [0:MAX_ORDER];
	logic [CW-1:0]     c_x     [0:MAX_ORDER];
	logic [CW-1:0]     c_y     [0:MAX_ORDER];
	logic [IW-1:0]     c_d     [0:MAX_ORDER];

	logic [CRD_W-1:0]  out_x;
	logic [CRD_W-1:0]  out_y;
	logic [IDX_W-1:0]  out_index;

	assign cfg_ready = 1'b1;

	// saturate at write time so the cells compare against a plain level count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= OW'(RST_O);
		end else if (cfg_valid && cfg_ready) begin
			order_q <= (cfg_data > MAX_CFG) ? OW'(MAX_ORDER) : OW'(cfg_data);
		end
	end

	// point to index starts with a clear distance, index to point with a clear point
	always_comb begin
		c_valid[0] = s_tvalid;
		c_kind[0]  = hcic_pkg::kind_t'(s_tuser[0]);
		if (s_tuser[0] == hcic_pkg::KIND_D2XY) begin
			c_x[0] = '0;
			c_y[0] = '0;
			c_d[0] = IW'(s_tdata[2*CRD_W +: IDX_W]);
		end else begin
			c_x[0] = CW'(s_tdata[0 +: CRD_W]);
			c_y[0] = CW'(s_tdata[CRD_W +: CRD_W]);
			c_d[0] = '0;
		end
	end
	assign s_tready = c_ready[0];

	for (genvar k = 0; k < MAX_ORDER; k++) begin : g_cell
		hcic_cell #(
			.MAX_ORDER (MAX_ORDER),
			.STAGE     (k)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.order     (order_q),
			.in_valid  (c_valid[k]),
			.in_ready  (c_ready[k]),
			.in_kind   (c_kind[k]),
			.in_x      (c_x[k]),
			.in_y      (c_y[k]),
			.in_d      (c_d[k]),
			.out_valid (c_valid[k+1]),
			.out_ready (c_ready[k+1]),
			.out_kind  (c_kind[k+1]),
			.out_x     (c_x[k+1]),
			.out_y     (c_y[k+1]),
			.out_d     (c_d[k+1])
		);
	end

	assign c_ready[MAX_ORDER] = m_tready;
	assign m_tvalid = c_valid[MAX_ORDER];

	always_comb begin
		out_index = '0;
		out_x     = '0;
		out_y     = '0;
		unique case (c_kind[MAX_ORDER])
			hcic_pkg::KIND_XY2D: out_index = IDX_W'(c_d[MAX_ORDER]);
			hcic_pkg::KIND_D2XY: begin
				out_x = CRD_W'(c_x[MAX_ORDER]);
				out_y = CRD_W'(c_y[MAX_ORDER]);
			end
			default: out_index = '0;
		endcase
	end

	assign m_tdata = {out_y, out_x, out_index};

	// with the sink ready every cell drains, so the input side must be open
	`HCIC_ASSERT_NOW(a_top_ready_chain, m_tready, s_tready,
		"input stalled while the output is ready")
	// the stored order never leaves the supported range
	`HCIC_ASSERT_NOW(a_top_order_range, 1'b1, order_q <= OW'(MAX_ORDER),
		"curve order above its maximum")
	// a stalled result stays offered and unchanged
	`HCIC_ASSERT_NEXT(a_top_out_hold, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata), "result transaction changed while stalled")

endmodule

>>> src/hcic_cell.sv
// one bit level of the hilbert conversion with its pipeline register
// depends on hcic_pkg and the assertion header
`include "hilbert_curve_index_converter_core_assert.svh"

module hcic_cell #(
	parameter int MAX_ORDER = 16,
	parameter int STAGE     = 0
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [$clog2(MAX_ORDER+1)-1:0] order,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  hcic_pkg::kind_t              in_kind,
	input  logic [MAX_ORDER-1:0]         in_x,
	input  logic [MAX_ORDER-1:0]         in_y,
	input  logic [2*MAX_ORDER-1:0]       in_d,
	output logic                         out_valid,
	input  logic                         out_ready,
	output hcic_pkg::kind_t              out_kind,
	output logic [MAX_ORDER-1:0]         out_x,
	output logic [MAX_ORDER-1:0]         out_y,
	output logic [2*MAX_ORDER-1:0]       out_d
);

	localparam int OW = $clog2(MAX_ORDER + 1);
	localparam int CW = MAX_ORDER;
	localparam int IW = 2 * MAX_ORDER;
	// point to index walks from the top level down, index to point from level zero up
	localparam int LVL_P = MAX_ORDER - 1 - STAGE;
	localparam int LVL_D = STAGE;
	localparam logic [OW-1:0] LVL_P_O = OW'(LVL_P);
	localparam logic [OW-1:0] LVL_D_O = OW'(LVL_D);
	localparam logic [CW-1:0] MASK_P  = CW'((64'd1 << LVL_P) - 64'd1);
	localparam logic [CW-1:0] MASK_D  = CW'((64'd1 << LVL_D) - 64'd1);

	logic                 valid_q;
	hcic_pkg::kind_t      kind_q;
	logic [CW-1:0]        x_q;
	logic [CW-1:0]        y_q;
	logic [IW-1:0]        d_q;

	logic [CW-1:0]        x_n;
	logic [CW-1:0]        y_n;
	logic [IW-1:0]        d_n;
	logic [CW-1:0]        xm;
	logic [CW-1:0]        ym;
	logic                 rx;
	logic                 ry;
	logic                 take;

	assign in_ready = !valid_q || out_ready;
	assign take     = in_valid && in_ready;

	always_comb begin
		x_n = in_x;
		y_n = in_y;
		d_n = in_d;
		rx  = 1'b0;
		ry  = 1'b0;
		xm  = '0;
		ym  = '0;
		unique case (in_kind)
			hcic_pkg::KIND_XY2D: begin
				if (LVL_P_O < order) begin
					rx = in_x[LVL_P];
					ry = in_y[LVL_P];
					d_n[2*LVL_P +: 2] = {rx, rx ^ ry};
					xm = in_x & MASK_P;
					ym = in_y & MASK_P;
					if (!ry) begin
						if (rx) begin
							xm = xm ^ MASK_P;
							ym = ym ^ MASK_P;
						end
						x_n = ym;
						y_n = xm;
					end else begin
						x_n = xm;
						y_n = ym;
					end
				end
			end
			hcic_pkg::KIND_D2XY: begin
				if (LVL_D_O < order) begin
					rx = in_d[2*LVL_D + 1];
					ry = in_d[2*LVL_D] ^ rx;
					xm = in_x;
					ym = in_y;
					if (!ry) begin
						if (rx) begin
							xm = xm ^ MASK_D;
							ym = ym ^ MASK_D;
						end
						x_n = ym;
						y_n = xm;
					end else begin
						x_n = xm;
						y_n = ym;
					end
					x_n[LVL_D] = rx;
					y_n[LVL_D] = ry;
				end
			end
			default: begin
				x_n = in_x;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			kind_q <= in_kind;
			x_q    <= x_n;
			y_q    <= y_n;
			d_q    <= d_n;
		end
	end

	assign out_valid = valid_q;
	assign out_kind  = kind_q;
	assign out_x     = x_q;
	assign out_y     = y_q;
	assign out_d     = d_q;

	// a stalled item keeps its place and its payload
	`HCIC_ASSERT_NEXT(a_cell_hold, valid_q && !out_ready,
		valid_q && $stable(d_q) && $stable(x_q), "cell lost or changed a stalled item")
	// index to point never builds coordinate bits above this level
	`HCIC_ASSERT_NOW(a_cell_coord_range, valid_q && kind_q == hcic_pkg::KIND_D2XY,
		(x_q & ~((CW'(1) << LVL_D) | MASK_D)) == '0, "coordinate grew past its level")
	// a new item only enters an empty or draining cell
	`HCIC_ASSERT_NOW(a_cell_no_overwrite, take && valid_q, out_ready,
		"cell overwrote an item not taken")

endmodule

>>> verif/tb.sv
// self-checking testbench for hilbert_curve_index_converter_core: directed rows, then
// random phases over several curve orders with bursty input and a stalling receiver
// depends on hcic_pkg and the converter rtl
module tb;

	localparam int MAX_ORDER      = 16;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int PHASE_ITEMS    = 72;
	localparam int NUM_PHASES     = 12;
	localparam int RANDOM_ORDER   = 99;
	localparam int CRD_W          = hcic_pkg::COORD_W;
	localparam int IDX_W          = hcic_pkg::INDEX_W;
	localparam int CFG_W          = hcic_pkg::CFG_W;

	// lowest bits first: out_index, out_x, out_y
	typedef struct packed {
		logic [CRD_W-1:0] y;
		logic [CRD_W-1:0] x;
		logic [IDX_W-1:0] index;
	} conv_res_t;

	// lowest bits first: coord_x, coord_y, curve_index
	typedef struct packed {
		logic [IDX_W-1:0] index;
		logic [CRD_W-1:0] y;
		logic [CRD_W-1:0] x;
	} conv_item_t;

	typedef struct packed {
		logic [CFG_W-1:0]   order;
		hcic_pkg::kind_t    kind;
		logic [CRD_W-1:0]   x;
		logic [CRD_W-1:0]   y;
		logic [IDX_W-1:0]   index;
		logic               typed;
		conv_res_t          want;
	} dir_row_t;

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [CFG_W-1:0]               cfg_data  = '0;
	logic                           s_tvalid  = 1'b0;
	logic                           s_tready;
	logic [hcic_pkg::S_TDATA_W-1:0] s_tdata   = '0;
	logic [0:0]                     s_tuser   = '0;
	logic                           m_tvalid;
	logic                           m_tready  = 1'b0;
	logic [hcic_pkg::M_TDATA_W-1:0] m_tdata;

	// expectation that travels with the offered item
	logic                 tx_typed  = 1'b0;
	conv_res_t            tx_want   = '0;

	conv_res_t            due_results[$];
	logic [CFG_W-1:0]     dut_order = CFG_W'(hcic_pkg::ORDER_RESET);
	int                   errors    = 0;
	int                   quiet     = 0;
	int                   hold_reqs = 0;
	int                   hold_taken = 0;
	int                   hold_left = 0;
	int                   rx_run    = 0;
	logic                 rx_free   = 1'b0;

	hilbert_curve_index_converter_core #(
		.MAX_ORDER(MAX_ORDER)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	function automatic logic [IDX_W-1:0] xy_to_dist(int ord, logic [CRD_W-1:0] px,
			logic [CRD_W-1:0] py);
		logic [31:0] x, y, s, tmp, acc;
		logic rx, ry;
		int lvl;
		x = 32'(px) & ((32'd1 << ord) - 32'd1);
		y = 32'(py) & ((32'd1 << ord) - 32'd1);
		acc = '0;
		for (lvl = ord - 1; lvl >= 0; lvl--) begin
			s = 32'd1 << lvl;
			rx = x[lvl];
			ry = y[lvl];
			// quadrant code 0,1,2,3 from (rx, ry)
			acc = acc | (32'({rx, rx ^ ry}) << (2 * lvl));
			x = x & (s - 32'd1);
			y = y & (s - 32'd1);
			if (!ry) begin
				if (rx) begin
					x = x ^ (s - 32'd1);
					y = y ^ (s - 32'd1);
				end
				tmp = x;
				x = y;
				y = tmp;
			end
		end
		return acc;
	endfunction

	function automatic conv_res_t dist_to_xy(int ord, logic [IDX_W-1:0] d);
		logic [63:0] t;
		logic [31:0] x, y, s, tmp;
		logic rx, ry;
		int lvl;
		conv_res_t r;
		t = 64'(d) & ((64'd1 << (2 * ord)) - 64'd1);
		x = '0;
		y = '0;
		for (lvl = 0; lvl < ord; lvl++) begin
			s = 32'd1 << lvl;
			rx = t[1];
			ry = t[0] ^ rx;
			if (!ry) begin
				if (rx) begin
					x = s - 32'd1 - x;
					y = s - 32'd1 - y;
				end
				tmp = x;
				x = y;
				y = tmp;
			end
			if (rx) x = x + s;
			if (ry) y = y + s;
			t = t >> 2;
		end
		r.index = '0;
		r.x = x[CRD_W-1:0];
		r.y = y[CRD_W-1:0];
		return r;
	endfunction

	function automatic conv_res_t hilbert_convert(hcic_pkg::kind_t kind, conv_item_t item,
			logic [CFG_W-1:0] order);
		int ord;
		conv_res_t r;
		ord = (int'(order) > MAX_ORDER) ? MAX_ORDER : int'(order);
		r = '0;
		if (kind == hcic_pkg::KIND_XY2D) r.index = xy_to_dist(ord, item.x, item.y);
		else r = dist_to_xy(ord, item.index);
		return r;
	endfunction

	// called at a rising edge, returns at the edge that accepts the item
	task automatic offer_item(hcic_pkg::kind_t k, logic [CRD_W-1:0] x,
			logic [CRD_W-1:0] y, logic [IDX_W-1:0] idx, logic typed, conv_res_t want);
		s_tvalid <= 1'b1;
		s_tuser  <= k;
		s_tdata  <= {idx, y, x};
		tx_typed <= typed;
		tx_want  <= want;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic offer_random(int ord);
		logic [CRD_W-1:0] x, y, cm;
		logic [IDX_W-1:0] idx;
		logic [63:0] im;
		hcic_pkg::kind_t k;
		cm = CRD_W'((32'd1 << ord) - 32'd1);
		im = (64'd1 << (2 * ord)) - 64'd1;
		k = hcic_pkg::kind_t'($urandom_range(0, 1));
		x = CRD_W'($urandom);
		y = CRD_W'($urandom);
		idx = $urandom;
		// mostly in range, sometimes full width to hit the masking
		if ($urandom_range(0, 3) != 0) begin
			x = x & cm;
			y = y & cm;
			idx = idx & IDX_W'(im);
		end
		offer_item(k, x, y, idx, 1'b0, '0);
	endtask

	// drain everything in flight, then write curve_order
	task automatic write_order(logic [CFG_W-1:0] v);
		s_tvalid <= 1'b0;
		do @(posedge clk); while (due_results.size() != 0);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// receiver: long hold on request, always ready while rx_free is set, else alternating ready and stall runs
	always @(posedge clk) begin
		if (hold_taken != hold_reqs) begin
			hold_taken <= hold_taken + 1;
			hold_left  <= HOLD_CYCLES;
			m_tready   <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else if (rx_free) begin
			m_tready <= 1'b1;
		end else if (rx_run != 0) begin
			rx_run <= rx_run - 1;
		end else begin
			m_tready <= ~m_tready;
			rx_run   <= m_tready ? $urandom_range(0, 6) : $urandom_range(0, 10);
		end
	end

	always @(posedge clk) begin : monitor
		conv_res_t got, want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) dut_order <= cfg_data;
			if (s_tvalid && s_tready) begin
				if (tx_typed) due_results.push_back(tx_want);
				else due_results.push_back(hilbert_convert(hcic_pkg::kind_t'(s_tuser),
					conv_item_t'(s_tdata), dut_order));
			end
			if (m_tvalid && m_tready) begin
				got = conv_res_t'(m_tdata);
				if (due_results.size() == 0) begin
					$error("result transaction with nothing expected: %h", m_tdata);
					errors++;
				end else begin
					want = due_results.pop_front();
					if (got.index !== want.index) begin
						$error("out_index: expected %0h, got %0h", want.index, got.index);
						errors++;
					end
					if (got.x !== want.x) begin
						$error("out_x: expected %0h, got %0h", want.x, got.x);
						errors++;
					end
					if (got.y !== want.y) begin
						$error("out_y: expected %0h, got %0h", want.y, got.y);
						errors++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else if (quiet >= WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin
		dir_row_t rows[$];
		dir_row_t r;
		int phase_cfg[NUM_PHASES] = '{16, 8, 0, 31, 1, 2, 3, 17, 5, 12, 15, RANDOM_ORDER};
		logic [CFG_W-1:0] cur_cfg;
		logic [CFG_W-1:0] v;
		int eff, sent, burst, gap, b, p;

		cur_cfg = CFG_W'(hcic_pkg::ORDER_RESET);
		// want fields: {out_y, out_x, out_index}
		// reset order: curve ends and masking
		rows.push_back('{5'd8, hcic_pkg::KIND_XY2D, 16'h0000, 16'h0000, 32'h0, 1'b1,
			64'd0});
		rows.push_back('{5'd8, hcic_pkg::KIND_D2XY, 16'h0000, 16'h0000, 32'h0, 1'b1,
			64'd0});
		rows.push_back('{5'd8, hcic_pkg::KIND_XY2D, 16'h00ff, 16'h0000, 32'h0, 1'b1,
			{16'h0, 16'h0, 32'h0000ffff}});
		rows.push_back('{5'd8, hcic_pkg::KIND_D2XY, 16'h0000, 16'h0000, 32'h0000ffff,
			1'b1, {16'h0, 16'h00ff, 32'h0}});
		rows.push_back('{5'd8, hcic_pkg::KIND_XY2D, 16'hffff, 16'hff00, 32'h0, 1'b1,
			{16'h0, 16'h0, 32'h0000ffff}});
		rows.push_back('{5'd8, hcic_pkg::KIND_D2XY, 16'hffff, 16'hffff, 32'hffffffff,
			1'b1, {16'h0, 16'h00ff, 32'h0}});
		rows.push_back('{5'd8, hcic_pkg::KIND_XY2D, 16'hffff, 16'hffff, 32'hffffffff,
			1'b0, 64'd0});
		rows.push_back('{5'd8, hcic_pkg::KIND_XY2D, 16'h0080, 16'h0080, 32'h0, 1'b0,
			64'd0});
		rows.push_back('{5'd8, hcic_pkg::KIND_D2XY, 16'h0000, 16'h0000, 32'h00005555,
			1'b0, 64'd0});
		rows.push_back('{5'd8, hcic_pkg::KIND_D2XY, 16'h0000, 16'h0000, 32'h0000aaaa,
			1'b0, 64'd0});
		// one-cell grid
		rows.push_back('{5'd0, hcic_pkg::KIND_XY2D, 16'hffff, 16'hffff, 32'hffffffff,
			1'b1, 64'd0});
		rows.push_back('{5'd0, hcic_pkg::KIND_D2XY, 16'hffff, 16'hffff, 32'hffffffff,
			1'b1, 64'd0});
		// 2x2 grid
		rows.push_back('{5'd1, hcic_pkg::KIND_XY2D, 16'h0001, 16'h0001, 32'h0, 1'b1,
			{16'h0, 16'h0, 32'h2}});
		rows.push_back('{5'd1, hcic_pkg::KIND_XY2D, 16'h0001, 16'h0000, 32'h0, 1'b1,
			{16'h0, 16'h0, 32'h3}});
		rows.push_back('{5'd1, hcic_pkg::KIND_D2XY, 16'h0000, 16'h0000, 32'h1, 1'b1,
			{16'h1, 16'h0, 32'h0}});
		rows.push_back('{5'd1, hcic_pkg::KIND_D2XY, 16'h0000, 16'h0000, 32'hfffffffe,
			1'b1, {16'h1, 16'h1, 32'h0}});
		// order above the maximum acts as the maximum
		rows.push_back('{5'd31, hcic_pkg::KIND_XY2D, 16'hffff, 16'h0000, 32'h0, 1'b1,
			{16'h0, 16'h0, 32'hffffffff}});
		rows.push_back('{5'd31, hcic_pkg::KIND_D2XY, 16'h0000, 16'h0000, 32'hffffffff,
			1'b1, {16'h0, 16'hffff, 32'h0}});
		rows.push_back('{5'd31, hcic_pkg::KIND_XY2D, 16'h0000, 16'hffff, 32'h0, 1'b0,
			64'd0});
		rows.push_back('{5'd31, hcic_pkg::KIND_D2XY, 16'h0000, 16'h0000, 32'h80000000,
			1'b0, 64'd0});
		rows.push_back('{5'd16, hcic_pkg::KIND_XY2D, 16'h8000, 16'h7fff, 32'h0, 1'b0,
			64'd0});
		rows.push_back('{5'd16, hcic_pkg::KIND_D2XY, 16'h0000, 16'h0000, 32'h12345678,
			1'b0, 64'd0});
		rows.push_back('{5'd17, hcic_pkg::KIND_D2XY, 16'h0000, 16'h0000, 32'hffffffff,
			1'b1, {16'h0, 16'hffff, 32'h0}});

		repeat (12) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			r = rows[i];
			if (r.order != cur_cfg) begin
				write_order(r.order);
				cur_cfg = r.order;
			end
			offer_item(r.kind, r.x, r.y, r.index, r.typed, r.want);
			if ($urandom_range(0, 2) == 0) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end

		for (p = 0; p < NUM_PHASES; p++) begin
			v = (phase_cfg[p] == RANDOM_ORDER) ? CFG_W'($urandom_range(0, 31)) :
				CFG_W'(phase_cfg[p]);
			write_order(v);
			cur_cfg = v;
			eff = (int'(v) > MAX_ORDER) ? MAX_ORDER : int'(v);
			// second phase runs with no idling on either side
			rx_free <= (p == 1);
			// first phase: receiver holds off while input keeps coming
			if (p == 0) hold_reqs <= hold_reqs + 1;
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				burst = $urandom_range(1, 24);
				for (b = 0; b < burst && sent < PHASE_ITEMS; b++) begin
					offer_random(eff);
					sent++;
				end
				gap = (p == 1) ? 0 : $urandom_range(0, 10);
				if (gap != 0) begin
					s_tvalid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end

		s_tvalid <= 1'b0;
		rx_free  <= 1'b0;
		do @(posedge clk); while (due_results.size() != 0);
		repeat (MAX_ORDER + 8) @(posedge clk);
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

>>> filelist.f
+incdir+src
src/hcic_pkg.sv
src/hcic_cell.sv
src/hilbert_curve_index_converter_core.sv
verif/tb.sv
